>>> rtl/cau_pkg.sv
// cau_pkg: shared types and constants for the complex arithmetic unit
// no dependencies
package cau_pkg;

    localparam int unsigned CAU_DATA_WIDTH = 32;
    localparam int unsigned CAU_FRAC_BITS  = 16;
    localparam int unsigned CAU_FIELD_W    = 32;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

endpackage

>>> rtl/complex_arithmetic_unit_core.sv
// complex_arithmetic_unit_core: pipelined complex add, subtract, multiply and divide
// in signed fixed point, with saturation and divide-by-zero status; uses cau_pkg
// throughput: one beat per cycle while the result side does not stall;
// the divider is DATA_WIDTH + 2 restoring stages, one bit each
// stalls propagate stage by stage, so bubbles are filled while a result waits
// reset: synchronous, active low, clears all valid bits
module complex_arithmetic_unit_core
    import cau_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = CAU_DATA_WIDTH,
    parameter int unsigned FRAC_BITS  = CAU_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [4*CAU_FIELD_W-1:0] i_s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]             i_s_tuser,  // mode
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [2*CAU_FIELD_W-1:0] o_m_tdata,  // res_re, res_im
    output logic [1:0]             o_m_tuser   // status
);

    localparam int unsigned DW   = DATA_WIDTH;
    localparam int unsigned FW   = CAU_FIELD_W;
    localparam int unsigned PW   = 2 * DW;
    localparam int unsigned SW   = 2 * DW + 1;
    localparam int unsigned QB   = DW + 1;
    localparam int unsigned NDIV = QB + 1;
    localparam int unsigned MXS  = (FRAC_BITS > QB) ? FRAC_BITS : QB;
    localparam int unsigned CW   = 2 * DW + MXS + 1;
    localparam int unsigned NST  = NDIV + 5;
    localparam int unsigned OST  = NST - 1;

    localparam logic signed [SW-1:0] MAXV = (SW'(1) <<< (DW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -(SW'(1) <<< (DW - 1));
    localparam logic signed [SW-1:0] BIGV = SW'(1) <<< DW;

    typedef struct packed {
        t_mode                 mode;
        logic                  dz;
        logic signed [SW-1:0]  val_re;
        logic signed [SW-1:0]  val_im;
        logic [CW-1:0]         rem_re;
        logic [CW-1:0]         rem_im;
        logic [NDIV-1:0]       q_re;
        logic [NDIV-1:0]       q_im;
        logic                  neg_re;
        logic                  neg_im;
        logic [PW-1:0]         den;
    } t_dstage;

    logic [NST-1:0] r_v;
    logic [NST-1:0] adv;

    assign adv[OST] = !r_v[OST] || i_m_tready;
    for (genvar k = 0; k < OST; k++) begin : g_adv
        assign adv[k] = !r_v[k] || adv[k+1];
    end

    assign o_s_tready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: input capture
    t_mode                r0_mode;
    logic signed [DW-1:0] r0_ar, r0_ai, r0_br, r0_bi;

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_mode <= t_mode'(i_s_tuser);
            r0_ar   <= $signed(i_s_tdata[0*FW +: DW]);
            r0_ai   <= $signed(i_s_tdata[1*FW +: DW]);
            r0_br   <= $signed(i_s_tdata[2*FW +: DW]);
            r0_bi   <= $signed(i_s_tdata[3*FW +: DW]);
        end
    end

    // stage 1: products and add/sub
    t_mode                r1_mode;
    logic                 r1_dz;
    logic signed [PW-1:0] r1_p0, r1_p1, r1_p2, r1_p3, r1_p4, r1_p5;
    logic signed [SW-1:0] r1_as_re, r1_as_im;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_mode <= r0_mode;
            r1_dz   <= (r0_br == '0) && (r0_bi == '0);
            r1_p0   <= PW'(r0_ar) * PW'(r0_br);
            r1_p1   <= PW'(r0_ai) * PW'(r0_bi);
            r1_p2   <= PW'(r0_ar) * PW'(r0_bi);
            r1_p3   <= PW'(r0_ai) * PW'(r0_br);
            r1_p4   <= PW'(r0_br) * PW'(r0_br);
            r1_p5   <= PW'(r0_bi) * PW'(r0_bi);
            if (r0_mode == MODE_SUB) begin
                r1_as_re <= SW'(r0_ar) - SW'(r0_br);
                r1_as_im <= SW'(r0_ai) - SW'(r0_bi);
            end else begin
                r1_as_re <= SW'(r0_ar) + SW'(r0_br);
                r1_as_im <= SW'(r0_ai) + SW'(r0_bi);
            end
        end
    end

    // stage 2: product sums and denominator
    t_mode                r2_mode;
    logic                 r2_dz;
    logic signed [SW-1:0] r2_s_re, r2_s_im;
    logic [PW-1:0]        r2_den;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_mode <= r1_mode;
            r2_dz   <= r1_dz;
            r2_den  <= $unsigned(r1_p4) + $unsigned(r1_p5);
            case (r1_mode)
                MODE_MUL: begin
                    r2_s_re <= SW'(r1_p0) - SW'(r1_p1);
                    r2_s_im <= SW'(r1_p2) + SW'(r1_p3);
                end
                MODE_DIV: begin
                    r2_s_re <= SW'(r1_p0) + SW'(r1_p1);
                    r2_s_im <= SW'(r1_p3) - SW'(r1_p2);
                end
                default: begin
                    r2_s_re <= r1_as_re;
                    r2_s_im <= r1_as_im;
                end
            endcase
        end
    end

    // stage 3: product scaling and divider setup
    t_dstage              n3;
    t_dstage              r3;
    logic [PW-1:0]        mag_re, mag_im;

    always_comb begin
        mag_re = r2_s_re[SW-1] ? PW'(-r2_s_re) : PW'(r2_s_re);
        mag_im = r2_s_im[SW-1] ? PW'(-r2_s_im) : PW'(r2_s_im);
        n3        = '0;
        n3.mode   = r2_mode;
        n3.dz     = r2_dz;
        n3.den    = r2_den;
        n3.neg_re = r2_s_re[SW-1];
        n3.neg_im = r2_s_im[SW-1];
        n3.rem_re = CW'(mag_re) << FRAC_BITS;
        n3.rem_im = CW'(mag_im) << FRAC_BITS;
        if (r2_mode == MODE_MUL) begin
            n3.val_re = r2_s_re >>> FRAC_BITS;
            n3.val_im = r2_s_im >>> FRAC_BITS;
        end else begin
            n3.val_re = r2_s_re;
            n3.val_im = r2_s_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3 <= n3;
        end
    end

    // divider: one quotient bit per stage, first stage flags overflow
    t_dstage r_d [NDIV];

    for (genvar j = 0; j < NDIV; j++) begin : g_div
        localparam int unsigned SH = QB - j;
        t_dstage       src;
        t_dstage       n_d;
        logic [CW-1:0] dsh;
        logic          ge_re, ge_im;

        if (j == 0) begin : g_first
            assign src = r3;
        end else begin : g_next
            assign src = r_d[j-1];
        end

        always_comb begin
            dsh   = CW'(src.den) << SH;
            ge_re = src.rem_re >= dsh;
            ge_im = src.rem_im >= dsh;
            n_d   = src;
            if (ge_re) begin
                n_d.rem_re = src.rem_re - dsh;
            end
            if (ge_im) begin
                n_d.rem_im = src.rem_im - dsh;
            end
            n_d.q_re = {src.q_re[NDIV-2:0], ge_re};
            n_d.q_im = {src.q_im[NDIV-2:0], ge_im};
        end

        always_ff @(posedge i_clk) begin
            if (adv[4+j]) begin
                r_d[j] <= n_d;
            end
        end
    end

    // output stage: quotient sign, clamp and status
    t_dstage              fin;
    logic signed [SW-1:0] v_re, v_im;
    logic                 sat_re, sat_im;
    logic signed [DW-1:0] c_re, c_im;
    logic [FW-1:0]        r_res_re, r_res_im;
    t_status              r_status;

    assign fin = r_d[NDIV-1];

    always_comb begin
        if (fin.mode == MODE_DIV) begin
            if (fin.q_re[NDIV-1]) begin
                v_re = fin.neg_re ? -BIGV : BIGV;
            end else begin
                v_re = fin.neg_re ? -$signed(SW'(fin.q_re[QB-1:0]))
                                  : $signed(SW'(fin.q_re[QB-1:0]));
            end
            if (fin.q_im[NDIV-1]) begin
                v_im = fin.neg_im ? -BIGV : BIGV;
            end else begin
                v_im = fin.neg_im ? -$signed(SW'(fin.q_im[QB-1:0]))
                                  : $signed(SW'(fin.q_im[QB-1:0]));
            end
        end else begin
            v_re = fin.val_re;
            v_im = fin.val_im;
        end
        sat_re = (v_re > MAXV) || (v_re < MINV);
        sat_im = (v_im > MAXV) || (v_im < MINV);
        c_re   = (v_re > MAXV) ? DW'(MAXV) : (v_re < MINV) ? DW'(MINV) : DW'(v_re);
        c_im   = (v_im > MAXV) ? DW'(MAXV) : (v_im < MINV) ? DW'(MINV) : DW'(v_im);
    end

    always_ff @(posedge i_clk) begin
        if (adv[OST]) begin
            if (fin.mode == MODE_DIV && fin.dz) begin
                r_res_re <= '0;
                r_res_im <= '0;
                r_status <= ST_DZ;
            end else begin
                r_res_re <= FW'(c_re);
                r_res_im <= FW'(c_im);
                r_status <= (sat_re || sat_im) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_v[OST];
    assign o_m_tdata  = {r_res_im, r_res_re};
    assign o_m_tuser  = r_status;

    function automatic logic signed [DW-1:0] c_max();
        return DW'(MAXV);
    endfunction

    function automatic logic signed [DW-1:0] c_min();
        return DW'(MINV);
    endfunction

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_DZ) |-> (o_m_tdata == '0))
        else $error("divide by zero beat carries nonzero data");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == ST_SAT) |->
        ($signed(r_res_re) == $signed(FW'(c_max())) || $signed(r_res_re) == $signed(FW'(c_min()))
         || $signed(r_res_im) == $signed(FW'(c_max()))
         || $signed(r_res_im) == $signed(FW'(c_min()))))
        else $error("saturated beat has no part at a bound");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted into a full stalled pipeline");

endmodule

>>> tb/complex_arithmetic_unit_core_test.sv
// complex_arithmetic_unit_core_test: self-checking bench for the complex alu core
// drives directed beats, then operand beats in random bursts, stalls the result side, and
// compares every result beat against a fixed-point predictor or a typed-in result; depends on cau_pkg and the core
module complex_arithmetic_unit_core_test;
    import cau_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = CAU_DATA_WIDTH + 7;
    localparam int N_RANDOM = 1150;
    localparam logic [31:0] MAX_P = 32'h7fffffff;
    localparam logic [31:0] MIN_N = 32'h80000000;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        t_status     st;
    } t_cresult;

    typedef struct {
        t_mode       mode;
        logic [31:0] a_re, a_im, b_re, b_im;
        bit          has_known;
        t_cresult    known;
    } t_vector;

    logic i_clk, i_rst_n;
    logic i_s_tvalid, i_m_tready;
    logic o_s_tready, o_m_tvalid;
    logic [127:0] i_s_tdata;
    logic [1:0] i_s_tuser;
    logic [63:0] o_m_tdata;
    logic [1:0] o_m_tuser;

    t_cresult expected_q[$];
    int err_count = 0;
    int idle_cycles = 0;

    complex_arithmetic_unit_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // clamp a wide signed value to 32 bits
    function automatic logic [31:0] clamp32(input logic signed [129:0] v, inout bit sat);
        if (v > 130'sh7fffffff) begin
            sat = 1;
            return MAX_P;
        end
        if (v < -130'sh80000000) begin
            sat = 1;
            return MIN_N;
        end
        return v[31:0];
    endfunction

    // truncating divide with magnitude cap, as the divider saturates huge quotients
    function automatic logic signed [129:0] quot(input logic signed [129:0] num,
                                                 input logic signed [129:0] den);
        logic signed [129:0] mag;
        logic signed [129:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< CAU_FRAC_BITS) / den;
        if (q >= (130'sd1 <<< 63)) q = 130'sd1 <<< 63;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_cresult complex_op(t_mode m, logic signed [31:0] ar,
                                            logic signed [31:0] ai,
                                            logic signed [31:0] br,
                                            logic signed [31:0] bi);
        logic signed [129:0] r, i, den;
        t_cresult res;
        bit sat;
        sat = 0;
        case (m)
            MODE_ADD: begin
                r = 130'(ar) + 130'(br);
                i = 130'(ai) + 130'(bi);
            end
            MODE_SUB: begin
                r = 130'(ar) - 130'(br);
                i = 130'(ai) - 130'(bi);
            end
            MODE_MUL: begin
                r = (130'(ar) * 130'(br) - 130'(ai) * 130'(bi)) >>> CAU_FRAC_BITS;
                i = (130'(ar) * 130'(bi) + 130'(br) * 130'(ai)) >>> CAU_FRAC_BITS;
            end
            default: begin
                den = 130'(br) * 130'(br) + 130'(bi) * 130'(bi);
                if (den == 0) begin
                    res.re = '0;
                    res.im = '0;
                    res.st = ST_DZ;
                    return res;
                end
                r = quot(130'(ar) * 130'(br) + 130'(ai) * 130'(bi), den);
                i = quot(130'(ai) * 130'(br) - 130'(ar) * 130'(bi), den);
            end
        endcase
        res.re = clamp32(r, sat);
        res.im = clamp32(i, sat);
        res.st = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // result side: stall pattern and checking
    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            case ((($time / 20) >> 7) % 3)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_cresult want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_q.size() == 0) begin
                $display("unexpected result beat at %0t", $time);
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (o_m_tdata[31:0] !== want.re) report_mismatch("re", o_m_tdata[31:0], want.re);
                if (o_m_tdata[63:32] !== want.im)
                    report_mismatch("im", o_m_tdata[63:32], want.im);
                if (o_m_tuser !== want.st)
                    report_mismatch("status", 32'(o_m_tuser), 32'(want.st));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MAX_P;
            1: return MIN_N;
            2: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
            3: return $urandom_range(0, 511) - 256;
            4: return 32'($signed($urandom() & 32'h00ffffff) - 32'sh00800000);
            5: return '0;
            default: return $urandom();
        endcase
    endfunction

    // one beat; the predictor result or a typed-in one goes on the queue at acceptance
    task automatic send_beat(input t_vector v);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {v.b_im, v.b_re, v.a_im, v.a_re};
        i_s_tuser <= v.mode;
        do @(posedge i_clk); while (!o_s_tready);
        expected_q.push_back(v.has_known ? v.known :
            complex_op(v.mode, v.a_re, v.a_im, v.b_re, v.b_im));
    endtask

    task automatic idle_gap(input int n);
        i_s_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic t_vector vec(t_mode m, logic [31:0] ar, logic [31:0] ai,
                                    logic [31:0] br, logic [31:0] bi,
                                    bit k, logic [31:0] r, logic [31:0] i, t_status s);
        t_vector v;
        v.mode = m; v.a_re = ar; v.a_im = ai; v.b_re = br; v.b_im = bi;
        v.has_known = k; v.known.re = r; v.known.im = i; v.known.st = s;
        return v;
    endfunction

    initial begin
        t_vector directed[$];
        t_vector v;
        int burst;
        bit drained;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = MODE_ADD;
        drained = 1'b0;
        directed = '{
            vec(MODE_ADD, 0, 0, 0, 0, 1'b1, 0, 0, ST_OK),
            vec(MODE_ADD, MAX_P, MIN_N, 1, 32'hffffffff, 1'b1, MAX_P, MIN_N, ST_SAT),
            vec(MODE_SUB, MIN_N, MAX_P, 1, 32'hffffffff, 1'b1, MIN_N, MAX_P, ST_SAT),
            vec(MODE_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00020000,
                1'b1, 32'h00020000, 32'hffff0000, ST_OK),
            vec(MODE_MUL, 32'h00020000, 0, 32'h00030000, 0, 1'b1, 32'h00060000, 0, ST_OK),
            vec(MODE_MUL, MAX_P, MAX_P, MAX_P, MAX_P, 1'b0, 0, 0, ST_OK),
            vec(MODE_MUL, MIN_N, MIN_N, MIN_N, MIN_N, 1'b0, 0, 0, ST_OK),
            vec(MODE_MUL, 32'hffffffff, 0, 1, 0, 1'b1, 32'hffffffff, 0, ST_OK),
            vec(MODE_MUL, 0, 32'h00010000, 0, 32'h00010000, 1'b1, 32'hffff0000, 0, ST_OK),
            vec(MODE_DIV, 32'h00050000, 32'h00010000, 0, 0, 1'b1, 0, 0, ST_DZ),
            vec(MODE_DIV, MIN_N, MAX_P, 0, 0, 1'b1, 0, 0, ST_DZ),
            vec(MODE_DIV, 32'h00060000, 0, 32'h00020000, 0, 1'b1, 32'h00030000, 0, ST_OK),
            vec(MODE_DIV, MAX_P, MAX_P, 1, 0, 1'b1, MAX_P, MAX_P, ST_SAT),
            vec(MODE_DIV, MIN_N, MIN_N, 1, 1, 1'b0, 0, 0, ST_OK),
            vec(MODE_DIV, 1, 32'hffffffff, MIN_N, MIN_N, 1'b0, 0, 0, ST_OK),
            vec(MODE_DIV, MAX_P, MIN_N, MAX_P, MIN_N, 1'b0, 0, 0, ST_OK),
            vec(MODE_DIV, 32'hffffffff, 0, 32'h00030000, 0, 1'b0, 0, 0, ST_OK)
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_beat(directed[k]);
        idle_gap($urandom_range(0, 5));
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                v.mode = t_mode'($urandom_range(0, 3));
                v.a_re = rand_operand();
                v.a_im = rand_operand();
                v.b_re = rand_operand();
                v.b_im = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_operand();
                if (v.mode == MODE_DIV && $urandom_range(0, 15) == 0) v.b_re = 0;
                v.has_known = 1'b0;
                send_beat(v);
            end
            if (!drained && n >= N_RANDOM / 2) begin
                // drain fully before resuming
                drained = 1'b1;
                i_s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 2) != 0) begin
                idle_gap($urandom_range(1, 45));
            end
        end
        i_s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
